FILE: sv/vital_sign_zscore_anomaly_risk_unit_assert.svh
// Assertion macros shared by the vital sign z-score block.
`ifndef VITAL_SIGN_ZSCORE_ANOMALY_RISK_UNIT_ASSERT_SVH
`define VITAL_SIGN_ZSCORE_ANOMALY_RISK_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VSZAR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define VSZAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/vszar_pkg.sv
// Types, codes, constants and band functions of the vital sign z-score block.
package vszar_pkg;

    localparam int ZW = 12;
    localparam int ZBW = 4;
    localparam logic [1:0] LAST_CH = 2'd3;

    localparam logic [10:0] Z_LIMIT_RST = 11'd512;
    localparam logic [3:0] CRIT_SCORE_RST = 4'd5;
    localparam logic [3:0] WARN_SCORE_RST = 4'd2;

    localparam logic [1:0] REG_Z_LIMIT = 2'd0;
    localparam logic [1:0] REG_CRIT_SCORE = 2'd1;
    localparam logic [1:0] REG_WARN_SCORE = 2'd2;

    localparam logic signed [10:0] TEMP_BAND3_LO = 11'sd350;
    localparam logic signed [10:0] TEMP_BAND3_HI = 11'sd395;
    localparam logic signed [10:0] TEMP_BAND2_LO = 11'sd360;
    localparam logic signed [10:0] TEMP_BAND2_HI = 11'sd380;
    localparam logic signed [10:0] TEMP_BAND1_LO = 11'sd365;
    localparam logic signed [10:0] TEMP_BAND1_HI = 11'sd375;
    localparam logic [7:0] HEART_BAND3_LO = 8'd50;
    localparam logic [7:0] HEART_BAND3_HI = 8'd120;
    localparam logic [7:0] HEART_BAND2_LO = 8'd55;
    localparam logic [7:0] HEART_BAND2_HI = 8'd100;
    localparam logic [7:0] HEART_BAND1_LO = 8'd60;
    localparam logic [7:0] HEART_BAND1_HI = 8'd90;
    localparam logic [6:0] OXY_BAND3 = 7'd90;
    localparam logic [6:0] OXY_BAND2 = 7'd94;
    localparam logic [6:0] OXY_BAND1 = 7'd97;

    typedef struct packed {
        logic signed [10:0] temp_tenths;
        logic [9:0] humidity_tenths;
        logic [7:0] pulse_bpm;
        logic [6:0] spo2_percent;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CH,
        ST_SUM,
        ST_NSQ,
        ST_SSQ,
        ST_VAR,
        ST_DEV,
        ST_DEN,
        ST_NUM,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_ZOUT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        LVL_NORMAL = 2'd0,
        LVL_WARNING = 2'd1,
        LVL_CRITICAL = 2'd2
    } level_t;

    typedef enum logic [2:0] {
        STS_OK = 3'd0,
        STS_WARNING = 3'd1,
        STS_CRITICAL = 3'd2,
        STS_ANOMALY = 3'd3,
        STS_CRIT_ANOMALY = 3'd4
    } status_t;

    function automatic logic signed [11:0] ch_value(input item_t it, input logic [1:0] ch);
        logic signed [11:0] v;
        unique case (ch)
            2'd0: v = 12'(it.temp_tenths);
            2'd1: v = $signed({2'b00, it.humidity_tenths});
            2'd2: v = $signed({4'b0000, it.pulse_bpm});
            default: v = $signed({5'b00000, it.spo2_percent});
        endcase
        return v;
    endfunction

    function automatic logic [1:0] temp_points(input logic signed [10:0] t);
        logic [1:0] p;
        priority if (t < TEMP_BAND3_LO || t > TEMP_BAND3_HI) p = 2'd3;
        else if (t < TEMP_BAND2_LO || t > TEMP_BAND2_HI) p = 2'd2;
        else if (t < TEMP_BAND1_LO || t > TEMP_BAND1_HI) p = 2'd1;
        else p = 2'd0;
        return p;
    endfunction

    function automatic logic [1:0] heart_points(input logic [7:0] h);
        logic [1:0] p;
        priority if (h < HEART_BAND3_LO || h > HEART_BAND3_HI) p = 2'd3;
        else if (h < HEART_BAND2_LO || h > HEART_BAND2_HI) p = 2'd2;
        else if (h < HEART_BAND1_LO || h > HEART_BAND1_HI) p = 2'd1;
        else p = 2'd0;
        return p;
    endfunction

    function automatic logic [1:0] oxygen_points(input logic [6:0] o);
        logic [1:0] p;
        priority if (o < OXY_BAND3) p = 2'd3;
        else if (o < OXY_BAND2) p = 2'd2;
        else if (o < OXY_BAND1) p = 2'd1;
        else p = 2'd0;
        return p;
    endfunction

    // Magnitude of a Q4.8 score; the most negative code reads as 2048.
    function automatic logic [11:0] z_mag(input logic signed [11:0] z);
        return z[11] ? 12'(-z) : 12'(z);
    endfunction

endpackage

FILE: sv/vszar_in_if.sv
// Reading channel: one item carries the four vital sign readings.
interface vszar_in_if;
    logic valid;
    logic ready;
    logic signed [10:0] temp_tenths;
    logic [9:0] humidity_tenths;
    logic [7:0] pulse_bpm;
    logic [6:0] spo2_percent;

    modport source (output valid, temp_tenths, humidity_tenths, pulse_bpm, spo2_percent,
                    input ready);
    modport sink (input valid, temp_tenths, humidity_tenths, pulse_bpm, spo2_percent,
                  output ready);
endinterface

FILE: sv/vszar_out_if.sv
// Result channel: one item carries the z-scores, anomaly flag and risk grading.
interface vszar_out_if;
    logic valid;
    logic ready;
    logic signed [11:0] z_temp;
    logic signed [11:0] z_humid;
    logic signed [11:0] z_heart;
    logic signed [11:0] z_oxygen;
    logic anomaly;
    logic [3:0] risk_score;
    logic [1:0] grade_level;
    logic [2:0] status_code;

    modport source (output valid, z_temp, z_humid, z_heart, z_oxygen, anomaly,
                    risk_score, grade_level, status_code, input ready);
    modport sink (input valid, z_temp, z_humid, z_heart, z_oxygen, anomaly,
                  risk_score, grade_level, status_code, output ready);
endinterface

FILE: sv/vszar_root.sv
// Bit-serial search for the largest m with m*m*den <= num, one bit a cycle.
module vszar_root #(
    parameter int RW = 73
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [RW-1:0] num,
    input  logic [RW-1:0] den,
    output logic [vszar_pkg::ZW-1:0] mag,
    output logic done
);
    import vszar_pkg::*;

    logic [RW-1:0] rem_reg;
    logic [RW-1:0] a_reg;
    logic [RW-1:0] b_reg;
    logic [ZW-1:0] mag_reg;
    logic [ZBW-1:0] bit_reg;
    logic busy_reg;
    logic done_reg;
    logic [RW-1:0] trial;
    logic take;

    // a_reg holds den << 2b and b_reg holds (den * m) << (b + 1), so the cost of
    // setting bit b is their sum and needs no multiplier.
    assign trial = b_reg + a_reg;
    assign take = busy_reg && (trial <= rem_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                bit_reg <= ZBW'(ZW - 1);
            end
            else if (busy_reg)
            begin
                if (bit_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    bit_reg <= bit_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            a_reg <= den << (2 * (ZW - 1));
            b_reg <= '0;
            mag_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_reg <= rem_reg - trial;
                mag_reg[bit_reg] <= 1'b1;
                b_reg <= (b_reg + (a_reg << 1)) >> 1;
            end
            else
            begin
                b_reg <= b_reg >> 1;
            end
            a_reg <= a_reg >> 2;
        end
    end

    assign mag = mag_reg;
    assign done = done_reg;

endmodule

FILE: sv/vital_sign_zscore_anomaly_risk_unit.sv
// Each accepted item is written into the rolling windows and then scored one
// channel at a time by a small sequencer around a single shared multiplier and
// a bit-serial root unit. A channel with three or more occupied entries is set
// up, swept through the window memory in a pipeline, put through six multiply
// steps, handed to the root unit, which resolves twelve bits, and stored; a
// flat window skips the last two multiply steps and the root, and with fewer
// than three entries a channel goes from set-up straight to storing a zero.
// The move into the output register waits for the consumer to take any
// previous result. The input is not ready until the result has been moved
// into the output register, which then waits for the consumer on its own.
module vital_sign_zscore_anomaly_risk_unit #(
    parameter int WINDOW_LEN = 20
) (
    input  logic clk,
    input  logic rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [3:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    vszar_in_if.sink sample,
    vszar_out_if.source result
);
    import vszar_pkg::*;

    localparam int NW = $clog2(WINDOW_LEN + 1);
    localparam int IW = $clog2(WINDOW_LEN);
    localparam int CW = $clog2(WINDOW_LEN + 2);
    localparam int SW = 12 + NW;
    localparam int QW = 22 + NW;
    localparam int MA = 24 + 2 * NW;
    localparam int MB = 12 + NW;
    localparam int PW = MA + MB;
    localparam int VW = 24 + 2 * NW;
    localparam int DW = 13 + NW;
    localparam int RW = PW + 16;

    state_t state_reg;
    state_t state_next;

    logic [10:0] z_limit_reg;
    logic [3:0] crit_score_reg;
    logic [3:0] warn_score_reg;

    logic [IW-1:0] slot_reg;
    logic [NW-1:0] fill_reg;
    logic [1:0] ch_reg;
    logic [CW-1:0] cnt_reg;
    logic v1_reg;
    logic v2_reg;
    logic out_valid_reg;

    item_t win_mem [WINDOW_LEN];
    item_t rd_reg;
    item_t in_reg;
    item_t in_item;

    logic signed [SW-1:0] sum_reg;
    logic [QW-1:0] sumsq_reg;
    logic [PW-1:0] prod_reg;
    logic [VW-2:0] p_reg;
    logic signed [VW-1:0] var_reg;
    logic signed [DW-1:0] dev_reg;
    logic [PW-1:0] den_reg;
    logic zero_reg;
    logic signed [ZW-1:0] z_reg [4];

    logic signed [ZW-1:0] z_out_reg [4];
    logic anomaly_reg;
    logic [3:0] score_reg;
    level_t level_reg;
    status_t status_reg;

    logic accept;
    logic cfg_write;
    logic [MA-1:0] mul_a;
    logic [MB-1:0] mul_b;
    logic [PW-1:0] mul_p;
    logic signed [11:0] rd_val;
    logic signed [11:0] x_val;
    logic [11:0] rd_abs;
    logic [11:0] x_abs;
    logic [MB-1:0] sum_abs;
    logic [DW-1:0] adev;
    logic [CW-1:0] n_ext;
    logic root_start;
    logic [ZW-1:0] root_mag;
    logic root_done;
    logic signed [ZW-1:0] z_new;
    logic anomaly_now;
    logic [3:0] score_now;
    level_t level_now;
    status_t status_now;
    logic out_load;

    assign in_item.temp_tenths = sample.temp_tenths;
    assign in_item.humidity_tenths = sample.humidity_tenths;
    assign in_item.pulse_bpm = sample.pulse_bpm;
    assign in_item.spo2_percent = sample.spo2_percent;

    assign sample.ready = (state_reg == ST_IDLE);
    assign accept = sample.valid && sample.ready;
    assign cfg_write = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_Z_LIMIT: prdata = 32'(z_limit_reg);
            REG_CRIT_SCORE: prdata = 32'(crit_score_reg);
            REG_WARN_SCORE: prdata = 32'(warn_score_reg);
            default: prdata = '0;
        endcase
    end

    assign rd_val = ch_value(rd_reg, ch_reg);
    assign x_val = ch_value(in_reg, ch_reg);
    assign rd_abs = rd_val[11] ? 12'(-rd_val) : 12'(rd_val);
    assign x_abs = x_val[11] ? 12'(-x_val) : 12'(x_val);
    assign sum_abs = sum_reg[SW-1] ? MB'(-sum_reg) : MB'(sum_reg);
    assign adev = dev_reg[DW-1] ? DW'(-dev_reg) : DW'(dev_reg);
    assign n_ext = CW'(fill_reg);
    assign mul_p = mul_a * mul_b;

    // Sequencer: next state, the operands of the shared multiplier, the root start and the output load.
    always_comb
    begin
        state_next = state_reg;
        mul_a = '0;
        mul_b = '0;
        root_start = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_CH;
            end
            ST_CH:
            begin
                if (fill_reg < NW'(3))
                    state_next = ST_ZOUT;
                else
                    state_next = ST_SUM;
            end
            ST_SUM:
            begin
                mul_a = MA'(rd_abs);
                mul_b = MB'(rd_abs);
                if (cnt_reg == n_ext + 1'b1)
                    state_next = ST_NSQ;
            end
            ST_NSQ:
            begin
                mul_a = MA'(sumsq_reg);
                mul_b = MB'(fill_reg);
                state_next = ST_SSQ;
            end
            ST_SSQ:
            begin
                mul_a = MA'(sum_abs);
                mul_b = sum_abs;
                state_next = ST_VAR;
            end
            ST_VAR:
            begin
                mul_a = MA'(x_abs);
                mul_b = MB'(fill_reg);
                state_next = ST_DEV;
            end
            ST_DEV:
            begin
                mul_a = MA'(var_reg[VW-2:0]);
                mul_b = MB'(fill_reg);
                if (var_reg[VW-1] || var_reg == '0)
                    state_next = ST_ZOUT;
                else
                    state_next = ST_DEN;
            end
            ST_DEN:
            begin
                mul_a = MA'(adev[DW-2:0]);
                mul_b = MB'(adev[DW-2:0]);
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                mul_a = prod_reg[MA-1:0];
                mul_b = MB'(fill_reg - 1'b1);
                state_next = ST_ROOT_GO;
            end
            ST_ROOT_GO:
            begin
                root_start = 1'b1;
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (root_done)
                    state_next = ST_ZOUT;
            end
            ST_ZOUT:
            begin
                if (ch_reg == LAST_CH)
                    state_next = ST_DONE;
                else
                    state_next = ST_CH;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    vszar_root #(
        .RW(RW)
    ) u_root (
        .clk(clk),
        .rst_n(rst_n),
        .start(root_start),
        .num({prod_reg, 16'b0}),
        .den(RW'(den_reg)),
        .mag(root_mag),
        .done(root_done)
    );

    // A root result of 2048 or more saturates; negative deviations keep -2048.
    always_comb
    begin
        if (zero_reg)
            z_new = '0;
        else if (dev_reg[DW-1])
            z_new = root_mag[ZW-1] ? $signed({1'b1, {(ZW-1){1'b0}}}) : -$signed(root_mag);
        else
            z_new = root_mag[ZW-1] ? $signed({1'b0, {(ZW-1){1'b1}}}) : $signed(root_mag);
    end

    always_comb
    begin
        anomaly_now = 1'b0;
        if (fill_reg == NW'(WINDOW_LEN))
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (z_mag(z_reg[i]) > 12'(z_limit_reg))
                    anomaly_now = 1'b1;
            end
        end
        score_now = 4'(temp_points(in_reg.temp_tenths)) + 4'(heart_points(in_reg.pulse_bpm))
                  + 4'(oxygen_points(in_reg.spo2_percent));
        priority if (score_now >= crit_score_reg)
            level_now = LVL_CRITICAL;
        else if (score_now >= warn_score_reg)
            level_now = LVL_WARNING;
        else
            level_now = LVL_NORMAL;
        priority if (anomaly_now && level_now == LVL_CRITICAL)
            status_now = STS_CRIT_ANOMALY;
        else if (anomaly_now)
            status_now = STS_ANOMALY;
        else if (level_now == LVL_CRITICAL)
            status_now = STS_CRITICAL;
        else if (level_now == LVL_WARNING)
            status_now = STS_WARNING;
        else
            status_now = STS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            z_limit_reg <= Z_LIMIT_RST;
            crit_score_reg <= CRIT_SCORE_RST;
            warn_score_reg <= WARN_SCORE_RST;
            slot_reg <= '0;
            fill_reg <= '0;
            ch_reg <= '0;
            cnt_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (paddr[3:2])
                    REG_Z_LIMIT: z_limit_reg <= pwdata[10:0];
                    REG_CRIT_SCORE: crit_score_reg <= pwdata[3:0];
                    REG_WARN_SCORE: warn_score_reg <= pwdata[3:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                slot_reg <= (slot_reg == IW'(WINDOW_LEN - 1)) ? '0 : slot_reg + 1'b1;
                if (fill_reg < NW'(WINDOW_LEN))
                    fill_reg <= fill_reg + 1'b1;
                ch_reg <= '0;
            end
            if (state_reg == ST_CH)
            begin
                cnt_reg <= '0;
                v1_reg <= 1'b0;
                v2_reg <= 1'b0;
            end
            else if (state_reg == ST_SUM)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                v1_reg <= (cnt_reg < n_ext);
                v2_reg <= v1_reg;
            end
            if (state_reg == ST_ZOUT && ch_reg != LAST_CH)
                ch_reg <= ch_reg + 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            win_mem[slot_reg] <= in_item;
        rd_reg <= win_mem[cnt_reg[IW-1:0]];
    end

    // The sweep is three deep: read, then sum and square, then add the square.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (accept)
            in_reg <= in_item;
        if (state_reg == ST_CH)
        begin
            sum_reg <= '0;
            sumsq_reg <= '0;
            zero_reg <= (fill_reg < NW'(3));
        end
        if (state_reg == ST_SUM)
        begin
            if (v1_reg)
                sum_reg <= sum_reg + SW'(rd_val);
            if (v2_reg)
                sumsq_reg <= sumsq_reg + QW'(prod_reg);
        end
        if (state_reg == ST_SSQ)
            p_reg <= prod_reg[VW-2:0];
        if (state_reg == ST_VAR)
            var_reg <= $signed({1'b0, p_reg}) - $signed({1'b0, prod_reg[VW-2:0]});
        if (state_reg == ST_DEV)
        begin
            dev_reg <= (x_val[11] ? -$signed({1'b0, prod_reg[DW-2:0]})
                                  : $signed({1'b0, prod_reg[DW-2:0]})) - DW'(sum_reg);
            zero_reg <= var_reg[VW-1] || var_reg == '0;
        end
        if (state_reg == ST_DEN)
            den_reg <= prod_reg;
        if (state_reg == ST_ZOUT)
            z_reg[ch_reg] <= z_new;
        if (out_load)
        begin
            for (int i = 0; i < 4; i++)
                z_out_reg[i] <= z_reg[i];
            anomaly_reg <= anomaly_now;
            score_reg <= score_now;
            level_reg <= level_now;
            status_reg <= status_now;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.z_temp = z_out_reg[0];
    assign result.z_humid = z_out_reg[1];
    assign result.z_heart = z_out_reg[2];
    assign result.z_oxygen = z_out_reg[3];
    assign result.anomaly = anomaly_reg;
    assign result.risk_score = score_reg;
    assign result.grade_level = level_reg;
    assign result.status_code = status_reg;

`include "vital_sign_zscore_anomaly_risk_unit_assert.svh"

    `VSZAR_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= NW'(WINDOW_LEN), "fill count beyond window")
    `VSZAR_ASSERT_NOW(a_root_in_wait, root_done, state_reg == ST_ROOT_WAIT, "root done out of turn")
    `VSZAR_ASSERT_NEXT(a_accept_starts, accept, state_reg == ST_CH && ch_reg == 2'd0, "item not started")
    `VSZAR_ASSERT_NEXT(a_load_valid, out_load, out_valid_reg && state_reg == ST_IDLE, "result not shown")

endmodule

FILE: verif/vital_sign_zscore_anomaly_risk_unit_checker.sv
// Checker for the vital sign z-score block: predicts every result item and compares it.
`timescale 1ns / 100ps
module vital_sign_zscore_anomaly_risk_unit_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [3:0] paddr,
    input  logic [31:0] pwdata,
    input  logic pready,
    vszar_in_if in_ch,
    vszar_out_if out_ch,
    output int fail_count,
    output int pending
);
    import vszar_pkg::*;

    localparam int DEPTH = 20;

    typedef struct packed {
        logic signed [11:0] z_temp;
        logic signed [11:0] z_humid;
        logic signed [11:0] z_heart;
        logic signed [11:0] z_oxygen;
        logic anomaly;
        logic [3:0] risk_score;
        logic [1:0] grade_level;
        logic [2:0] status_code;
    } grade_t;

    grade_t expected_grades[$];

    logic [10:0] lim_q;
    logic [3:0] crit_q;
    logic [3:0] warn_q;
    int temp_hist[DEPTH];
    int hum_hist[DEPTH];
    int heart_hist[DEPTH];
    int oxy_hist[DEPTH];
    int slot_q;
    int occupied;

    task automatic report(input string field, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", field, got, want, $time);
        fail_count++;
    endtask

    // Q4.8 z-score of x against the first n entries of a window.
    function automatic logic signed [11:0] window_z(input int w[DEPTH], input int n,
                                                    input int x);
        longint sum, sumsq, var_n, dev;
        longint unsigned adev, num, den, mag, lo, hi, mid;
        sum = 0;
        sumsq = 0;
        if (n < 3)
            return 12'sd0;
        for (int i = 0; i < n; i++)
        begin
            sum += w[i];
            sumsq += longint'(w[i]) * w[i];
        end
        var_n = longint'(n) * sumsq - sum * sum;
        if (var_n <= 0)
            return 12'sd0;
        dev = longint'(n) * x - sum;
        adev = dev < 0 ? -dev : dev;
        num = adev * adev * (n - 1) * 65536;
        den = longint'(n) * var_n;
        if (num >= 4194304 * den)
            mag = 2048;
        else
        begin
            lo = 0;
            hi = 2047;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) >> 1;
                if (mid * mid * den <= num)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            mag = lo;
        end
        if (dev < 0)
            return 12'(-mag);
        return mag > 2047 ? 12'sd2047 : 12'(mag);
    endfunction

    function automatic int band_temp(input int t);
        if (t < 350 || t > 395) return 3;
        if (t < 360 || t > 380) return 2;
        if (t < 365 || t > 375) return 1;
        return 0;
    endfunction

    function automatic int band_heart(input int h);
        if (h < 50 || h > 120) return 3;
        if (h < 55 || h > 100) return 2;
        if (h < 60 || h > 90) return 1;
        return 0;
    endfunction

    function automatic int band_oxy(input int o);
        if (o < 90) return 3;
        if (o < 94) return 2;
        if (o < 97) return 1;
        return 0;
    endfunction

    task automatic grade_reading(input int t, input int h, input int hr, input int o);
        grade_t g;
        int score;
        int zs[4];
        level_t lvl;
        temp_hist[slot_q] = t;
        hum_hist[slot_q] = h;
        heart_hist[slot_q] = hr;
        oxy_hist[slot_q] = o;
        slot_q = (slot_q + 1) % DEPTH;
        if (occupied < DEPTH)
            occupied++;
        g.z_temp = window_z(temp_hist, occupied, t);
        g.z_humid = window_z(hum_hist, occupied, h);
        g.z_heart = window_z(heart_hist, occupied, hr);
        g.z_oxygen = window_z(oxy_hist, occupied, o);
        zs[0] = g.z_temp;
        zs[1] = g.z_humid;
        zs[2] = g.z_heart;
        zs[3] = g.z_oxygen;
        g.anomaly = 1'b0;
        if (occupied >= DEPTH)
            foreach (zs[i])
                if ((zs[i] < 0 ? -zs[i] : zs[i]) > int'(lim_q))
                    g.anomaly = 1'b1;
        score = band_temp(t) + band_heart(hr) + band_oxy(o);
        if (score >= crit_q)
            lvl = LVL_CRITICAL;
        else if (score >= warn_q)
            lvl = LVL_WARNING;
        else
            lvl = LVL_NORMAL;
        g.risk_score = 4'(score);
        g.grade_level = lvl;
        if (g.anomaly && lvl == LVL_CRITICAL)
            g.status_code = STS_CRIT_ANOMALY;
        else if (g.anomaly)
            g.status_code = STS_ANOMALY;
        else if (lvl == LVL_CRITICAL)
            g.status_code = STS_CRITICAL;
        else if (lvl == LVL_WARNING)
            g.status_code = STS_WARNING;
        else
            g.status_code = STS_OK;
        expected_grades.push_back(g);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grade_t want;
        if (!rst_n)
        begin
            lim_q <= Z_LIMIT_RST;
            crit_q <= CRIT_SCORE_RST;
            warn_q <= WARN_SCORE_RST;
            slot_q = 0;
            occupied = 0;
            fail_count = 0;
            expected_grades.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[3:2] == REG_Z_LIMIT)
                    lim_q <= pwdata[10:0];
                else if (paddr[3:2] == REG_CRIT_SCORE)
                    crit_q <= pwdata[3:0];
                else if (paddr[3:2] == REG_WARN_SCORE)
                    warn_q <= pwdata[3:0];
            end
            if (in_ch.valid && in_ch.ready)
                grade_reading(in_ch.temp_tenths, in_ch.humidity_tenths,
                              in_ch.pulse_bpm, in_ch.spo2_percent);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_grades.size() == 0)
                begin
                    report("unexpected result item", 1, 0);
                end
                else
                begin
                    want = expected_grades.pop_front();
                    if (out_ch.z_temp !== want.z_temp)
                        report("z_temp", out_ch.z_temp, want.z_temp);
                    if (out_ch.z_humid !== want.z_humid)
                        report("z_humid", out_ch.z_humid, want.z_humid);
                    if (out_ch.z_heart !== want.z_heart)
                        report("z_heart", out_ch.z_heart, want.z_heart);
                    if (out_ch.z_oxygen !== want.z_oxygen)
                        report("z_oxygen", out_ch.z_oxygen, want.z_oxygen);
                    if (out_ch.anomaly !== want.anomaly)
                        report("anomaly", out_ch.anomaly, want.anomaly);
                    if (out_ch.risk_score !== want.risk_score)
                        report("risk_score", out_ch.risk_score, want.risk_score);
                    if (out_ch.grade_level !== want.grade_level)
                        report("grade_level", out_ch.grade_level, want.grade_level);
                    if (out_ch.status_code !== want.status_code)
                        report("status_code", out_ch.status_code, want.status_code);
                end
            end
            pending = expected_grades.size();
        end
    end
endmodule

FILE: verif/vital_sign_zscore_anomaly_risk_unit_test.sv
// Top of the testbench: clock, reset, register writes, readings and the verdict.
`timescale 1ns / 100ps
module vital_sign_zscore_anomaly_risk_unit_test;
    import vszar_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    int fail_count;
    int pending;
    int cycles = 0;
    bit calm = 1'b0;

    vszar_in_if sample_ch();
    vszar_out_if result_ch();

    vital_sign_zscore_anomaly_risk_unit dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .sample(sample_ch.sink), .result(result_ch.source)
    );

    vital_sign_zscore_anomaly_risk_unit_checker checker_i (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .in_ch(sample_ch), .out_ch(result_ch),
        .fail_count(fail_count), .pending(pending)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("vital_sign_zscore_anomaly_risk_unit verification failed");
            $finish;
        end
    end

    // The consumer stalls now and then, except during the calm stretch.
    always @(negedge clk)
        result_ch.ready <= calm || ($urandom_range(99) >= 7);

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Valid stays high from one item to the next unless the source idles.
    task automatic send_reading(input logic [10:0] t, input logic [9:0] h,
                                input logic [7:0] hr, input logic [6:0] o);
        while (!calm && $urandom_range(99) < 7)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.temp_tenths <= t;
        sample_ch.humidity_tenths <= h;
        sample_ch.pulse_bpm <= hr;
        sample_ch.spo2_percent <= o;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        @(negedge clk);
    endtask

    task automatic drain;
        sample_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200)
            @(negedge clk);
    endtask

    // Mostly readings near the clinical bands; some raw bit patterns.
    task automatic random_reading;
        if ($urandom_range(9) < 8)
            send_reading(11'($urandom_range(340, 405)), 10'($urandom_range(300, 700)),
                         8'($urandom_range(40, 130)), 7'($urandom_range(85, 100)));
        else
            send_reading(11'($urandom), 10'($urandom), 8'($urandom), 7'($urandom));
    endtask

    initial
    begin
        sample_ch.valid = 1'b0;
        sample_ch.temp_tenths = '0;
        sample_ch.humidity_tenths = '0;
        sample_ch.pulse_bpm = '0;
        sample_ch.spo2_percent = '0;
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;
        // Flat window first, then band edges and field extremes.
        repeat (4)
            send_reading(11'd370, 10'd500, 8'd75, 7'd98);
        send_reading(11'h400, 10'd0, 8'd0, 7'd0);
        send_reading(11'h3ff, 10'h3ff, 8'hff, 7'h7f);
        send_reading(11'd349, 10'd1000, 8'd49, 7'd89);
        send_reading(11'd350, 10'd0, 8'd50, 7'd90);
        send_reading(11'd395, 10'd1, 8'd120, 7'd93);
        send_reading(11'd396, 10'd2, 8'd121, 7'd94);
        send_reading(11'd359, 10'd3, 8'd54, 7'd96);
        send_reading(11'd360, 10'd4, 8'd55, 7'd97);
        send_reading(11'd380, 10'd5, 8'd100, 7'd100);
        send_reading(11'd381, 10'd6, 8'd101, 7'd95);
        send_reading(11'd364, 10'd7, 8'd59, 7'd99);
        send_reading(11'd365, 10'd8, 8'd60, 7'd98);
        send_reading(11'd375, 10'd9, 8'd90, 7'd98);
        send_reading(11'd376, 10'd10, 8'd91, 7'd98);
        repeat (5)
            send_reading(11'd370, 10'd500, 8'd75, 7'd98);
        // One outlier in every channel once the window is full.
        send_reading(11'h400, 10'd1000, 8'd255, 7'd0);
        drain();
        for (int phase = 0; phase < 6; phase++)
        begin
            unique case (phase)
                0:
                begin
                    write_reg(REG_Z_LIMIT, 0);
                    write_reg(REG_CRIT_SCORE, 0);
                    write_reg(REG_WARN_SCORE, 0);
                end
                1:
                begin
                    write_reg(REG_Z_LIMIT, 2047);
                    write_reg(REG_CRIT_SCORE, 15);
                    write_reg(REG_WARN_SCORE, 15);
                end
                2:
                begin
                    write_reg(REG_Z_LIMIT, 512);
                    write_reg(REG_CRIT_SCORE, 2);
                    write_reg(REG_WARN_SCORE, 7);
                end
                default:
                begin
                    write_reg(REG_Z_LIMIT, $urandom_range(2047));
                    write_reg(REG_CRIT_SCORE, $urandom_range(9));
                    write_reg(REG_WARN_SCORE, $urandom_range(9));
                end
            endcase
            calm = (phase == 3);
            repeat (210)
                random_reading();
            drain();
        end
        if (fail_count == 0)
            $display("vital_sign_zscore_anomaly_risk_unit verification clean");
        else
            $display("vital_sign_zscore_anomaly_risk_unit verification failed");
        $finish;
    end
endmodule
